@@ rtl/ptsmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsmp_pkg
// Shared types, constants and helpers for the polynomial trajectory sampler.
// ----------------------------------------------------------------------------
package ptsmp_pkg;

  localparam int unsigned TIME_EPSILON_DEF = 17;

  localparam int VAL_W    = 49;  // internal value, saturates to +-(2^48-1)
  localparam int DIV_QW   = 48;  // quotient bits of the time divider
  localparam int DIV_FRAC = 24;  // time fraction bits
  localparam int S_FRAC   = 30;  // normalized time fraction bits
  localparam int SP_W     = 31;  // power of s, 0..2^30
  localparam int H_W      = 44;  // basis value
  localparam int COEF_W   = 10;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [SP_W-1:0]         sp_t;
  typedef sp_t [5:0]               spv_t;
  typedef logic signed [H_W-1:0]   h_t;

  localparam logic [VAL_W-2:0] LIM_MAG = '1;
  localparam val_t LIM   = {1'b0, LIM_MAG};
  localparam val_t O_MAX = val_t'(32'sh7FFF_FFFF);
  localparam val_t O_MIN = val_t'(32'sh8000_0000);

  typedef enum logic [1:0] {
    ORD_LIN = 2'd0,
    ORD_CUB = 2'd1,
    ORD_QUI = 2'd2
  } ord_e;

  // [order][D, v0, vf, a0, af][derivative][power of s], doubled
  localparam logic signed [COEF_W-1:0] BASIS [3][5][3][6] = '{
    '{
      '{'{0, 2, 0, 0, 0, 0}, '{2, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}}
    },
    '{
      '{'{0, 0, 6, -4, 0, 0}, '{0, 12, -12, 0, 0, 0}, '{12, -24, 0, 0, 0, 0}},
      '{'{0, 2, -4, 2, 0, 0}, '{2, -8, 6, 0, 0, 0}, '{-8, 12, 0, 0, 0, 0}},
      '{'{0, 0, -2, 2, 0, 0}, '{0, -4, 6, 0, 0, 0}, '{-4, 12, 0, 0, 0, 0}},
      '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}}
    },
    '{
      '{'{0, 0, 0, 20, -30, 12}, '{0, 0, 60, -120, 60, 0}, '{0, 120, -360, 240, 0, 0}},
      '{'{0, 2, 0, -12, 16, -6}, '{2, 0, -36, 64, -30, 0}, '{0, -72, 192, -120, 0, 0}},
      '{'{0, 0, 0, -8, 14, -6}, '{0, 0, -24, 56, -30, 0}, '{0, -48, 168, -120, 0, 0}},
      '{'{0, 0, 1, -3, 3, -1}, '{0, 2, -9, 12, -5, 0}, '{2, -18, 36, -20, 0, 0}},
      '{'{0, 0, 0, 1, -2, 1}, '{0, 0, 3, -8, 5, 0}, '{0, 6, -24, 20, 0, 0}}
    }
  };

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        remaining_time;
    logic [31:0]        sample_time;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_pos;
    logic signed [31:0] next_vel;
    logic signed [31:0] next_acc;
  } out_t;

  // per-item context carried down the pipeline
  typedef struct packed {
    ord_e               ord;
    logic               spec;
    logic signed [31:0] sp_pos;
    logic signed [31:0] sp_vel;
    logic signed [31:0] sp_acc;
    logic [31:0]        tdur;
    logic signed [31:0] x0;
    logic signed [31:0] v0;
    logic signed [31:0] vf;
    logic signed [31:0] a0;
    logic signed [31:0] af;
    logic signed [32:0] dx;
    val_t [2:0]         gd;
    val_t [2:0]         gv;
    val_t [2:0]         ga;
    val_t               pacc;
    val_t               vacc;
    val_t               a_t;
    val_t               v_t;
    val_t               dd;
    val_t               dgv;
  } ctx_t;

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] lim_x;
    s     = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
    lim_x = $signed({1'b0, LIM});
    if (s > lim_x) begin
      return LIM;
    end else if (s < -lim_x) begin
      return -LIM;
    end
    return $signed(s[VAL_W-1:0]);
  endfunction

  function automatic logic signed [31:0] to_q16(input val_t x);
    val_t r;
    r = x;
    if (x > O_MAX) begin
      r = O_MAX;
    end else if (x < O_MIN) begin
      r = O_MIN;
    end
    return $signed(r[31:0]);
  endfunction

endpackage

@@ rtl/ptsmp_mulsh.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsmp_mulsh
// Pipelined signed multiply, right shift toward zero, saturate to +-(2^48-1).
// Three stages: magnitudes, two partial products, combine.
// ----------------------------------------------------------------------------
module ptsmp_mulsh #(
  parameter int  AW     = 33,
  parameter int  BW     = 44,
  parameter int  SH     = 31,
  parameter type side_t = logic
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  side_t                 side_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic                  vld_o,
  output side_t                 side_o,
  output ptsmp_pkg::val_t       y_o
);

  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;
  localparam logic [PW-1:0] LIM_W = PW'(ptsmp_pkg::LIM_MAG);

  logic [2:0]           vld_q;
  logic [AW-1:0]        am_q;
  logic [BW-1:0]        bm_q;
  logic                 neg1_q, neg2_q;
  side_t                side1_q, side2_q, side3_q;
  logic [AW+BL-1:0]     plo_q, plo_d;
  logic [AW+BH-1:0]     phi_q, phi_d;
  logic [PW-1:0]        full, shv;
  logic [ptsmp_pkg::VAL_W-2:0] mag;
  ptsmp_pkg::val_t      y_q, y_d;

  always_comb begin
    plo_d = (AW+BL)'(am_q) * (AW+BL)'(bm_q[BL-1:0]);
    phi_d = (AW+BH)'(am_q) * (AW+BH)'(bm_q[BW-1:BL]);
    full  = PW'(plo_q) + (PW'(phi_q) << BL);
    shv   = full >> SH;
    mag   = (shv > LIM_W) ? ptsmp_pkg::LIM_MAG : shv[ptsmp_pkg::VAL_W-2:0];
    y_d   = neg2_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    am_q    <= a_i[AW-1] ? $unsigned(-a_i) : $unsigned(a_i);
    bm_q    <= b_i[BW-1] ? $unsigned(-b_i) : $unsigned(b_i);
    neg1_q  <= a_i[AW-1] ^ b_i[BW-1];
    side1_q <= side_i;
    plo_q   <= plo_d;
    phi_q   <= phi_d;
    neg2_q  <= neg1_q;
    side2_q <= side1_q;
    y_q     <= y_d;
    side3_q <= side2_q;
  end

  assign vld_o  = vld_q[2];
  assign side_o = side3_q;
  assign y_o    = y_q;

endmodule

@@ rtl/ptsmp_divt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsmp_divt
// Pipelined time division y = (a * 2^24) / d, truncated toward zero and
// saturated. Restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptsmp_divt #(
  parameter type side_t = logic
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  side_t           side_i,
  input  ptsmp_pkg::val_t a_i,
  input  logic [31:0]     d_i,
  output logic            vld_o,
  output side_t           side_o,
  output ptsmp_pkg::val_t y_o
);

  localparam int QW = ptsmp_pkg::DIV_QW;
  localparam int FR = ptsmp_pkg::DIV_FRAC;
  localparam int VW = ptsmp_pkg::VAL_W;

  logic [VW-1:0]    mag;
  logic [VW-FR-1:0] hi;

  logic             vld_q  [QW+1];
  logic [31:0]      rem_q  [QW+1];
  logic [QW-1:0]    low_q  [QW+1];
  logic [QW-1:0]    quo_q  [QW+1];
  logic [31:0]      den_q  [QW+1];
  logic             neg_q  [QW+1];
  logic             ovf_q  [QW+1];
  side_t            side_q [QW+1];

  logic             vo_q;
  side_t            so_q;
  ptsmp_pkg::val_t  y_q, y_d;
  logic [VW-2:0]    qmag;

  always_comb begin
    mag = a_i[VW-1] ? $unsigned(-a_i) : $unsigned(a_i);
    hi  = mag[VW-1:FR];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      vo_q     <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      vo_q     <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= 32'(hi);
    low_q[0]  <= QW'({mag[FR-1:0], {(QW-FR){1'b0}}});
    quo_q[0]  <= '0;
    den_q[0]  <= d_i;
    neg_q[0]  <= a_i[VW-1];
    ovf_q[0]  <= 32'(hi) >= d_i;
    side_q[0] <= side_i;
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [32:0] r2, diff;
    logic        ge;

    always_comb begin
      r2   = {rem_q[j-1], low_q[j-1][QW-1]};
      diff = r2 - {1'b0, den_q[j-1]};
      ge   = r2 >= {1'b0, den_q[j-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= ge ? diff[31:0] : r2[31:0];
      low_q[j]  <= low_q[j-1] << 1;
      quo_q[j]  <= {quo_q[j-1][QW-2:0], ge};
      den_q[j]  <= den_q[j-1];
      neg_q[j]  <= neg_q[j-1];
      ovf_q[j]  <= ovf_q[j-1];
      side_q[j] <= side_q[j-1];
    end
  end

  always_comb begin
    qmag = ovf_q[QW] ? ptsmp_pkg::LIM_MAG : (VW-1)'(quo_q[QW]);
    y_d  = neg_q[QW] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk_i) begin
    y_q  <= y_d;
    so_q <= side_q[QW];
  end

  assign vld_o  = vo_q;
  assign side_o = so_q;
  assign y_o    = y_q;

endmodule

@@ rtl/polynomial_trajectory_sample.sv @@
`timescale 1ns / 1ps
// Throughput: one transfer per cycle.
// The three time dividers on the path (one bit per stage) dominate the latency.
// busy_o stays low: results are strobed on valid_o for one cycle, no back-pressure.
// Reset (rst_ni, async, active low) clears all valid bits; in-flight items are dropped.
// ----------------------------------------------------------------------------
// polynomial_trajectory_sample
// Samples a linear, cubic or quintic point-to-point trajectory at a given
// time and returns position, velocity and acceleration in Q16.16.
// ----------------------------------------------------------------------------
module polynomial_trajectory_sample #(
  parameter int unsigned TIME_EPSILON = ptsmp_pkg::TIME_EPSILON_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ptsmp_pkg::in_t    item_i,
  output logic              busy_o,
  output logic              valid_o,
  output ptsmp_pkg::out_t   result_o
);

  localparam int SP_W   = ptsmp_pkg::SP_W;
  localparam int S_FRAC = ptsmp_pkg::S_FRAC;

  // ---------------- front: decode, special cases
  ptsmp_pkg::ctx_t ctx_in;
  ptsmp_pkg::val_t s_num;
  logic            in_vld, short_seg, past_end;

  assign busy_o = 1'b0;
  assign in_vld = start_i & ~busy_o;

  always_comb begin
    ctx_in = '0;
    case (item_i.cmd)
      ptsmp_pkg::ORD_LIN: ctx_in.ord = ptsmp_pkg::ORD_LIN;
      ptsmp_pkg::ORD_CUB: ctx_in.ord = ptsmp_pkg::ORD_CUB;
      default:            ctx_in.ord = ptsmp_pkg::ORD_QUI;
    endcase
    short_seg = item_i.remaining_time < 32'(TIME_EPSILON);
    past_end  = (ctx_in.ord == ptsmp_pkg::ORD_LIN) ?
                (item_i.remaining_time < item_i.sample_time) :
                (item_i.remaining_time <= item_i.sample_time);
    ctx_in.spec   = short_seg | past_end;
    ctx_in.sp_pos = short_seg ? item_i.start_pos : item_i.end_pos;
    ctx_in.sp_vel = (ctx_in.ord == ptsmp_pkg::ORD_LIN) ? '0 :
                    (short_seg ? item_i.start_vel : item_i.end_vel);
    ctx_in.sp_acc = (ctx_in.ord != ptsmp_pkg::ORD_QUI) ? '0 :
                    (short_seg ? item_i.start_acc : item_i.end_acc);
    ctx_in.tdur   = item_i.remaining_time;
    ctx_in.x0     = item_i.start_pos;
    ctx_in.v0     = item_i.start_vel;
    ctx_in.vf     = item_i.end_vel;
    ctx_in.a0     = item_i.start_acc;
    ctx_in.af     = item_i.end_acc;
    ctx_in.dx     = $signed({item_i.end_pos[31], item_i.end_pos})
                  - $signed({item_i.start_pos[31], item_i.start_pos});
    s_num         = ptsmp_pkg::val_t'({item_i.sample_time, 6'b0});
  end

  // ---------------- s = t / T in Q1.30
  logic            ds_vld;
  ptsmp_pkg::ctx_t ds_ctx;
  ptsmp_pkg::val_t ds_y;

  ptsmp_divt #(.side_t(ptsmp_pkg::ctx_t)) u_div_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld),
    .side_i (ctx_in),
    .a_i    (s_num),
    .d_i    (item_i.remaining_time),
    .vld_o  (ds_vld),
    .side_o (ds_ctx),
    .y_o    (ds_y)
  );

  // ---------------- powers of s
  logic            pw_vld_q [5];
  ptsmp_pkg::ctx_t pw_ctx_q [5];
  ptsmp_pkg::spv_t pw_sp_q  [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_vld_q[0] <= 1'b0;
    end else begin
      pw_vld_q[0] <= ds_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_sp_q[0]  <= {{4{ptsmp_pkg::sp_t'(0)}}, ds_y[SP_W-1:0], SP_W'(1) << S_FRAC};
    pw_ctx_q[0] <= ds_ctx;
  end

  for (genvar j = 1; j < 5; j++) begin : g_pow
    logic [2*SP_W-1:0] prod;
    ptsmp_pkg::spv_t   sp_d;

    always_comb begin
      prod        = (2*SP_W)'(pw_sp_q[j-1][j]) * (2*SP_W)'(pw_sp_q[j-1][1]);
      sp_d        = pw_sp_q[j-1];
      sp_d[j+1]   = prod[S_FRAC+SP_W-1:S_FRAC];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pw_vld_q[j] <= 1'b0;
      end else begin
        pw_vld_q[j] <= pw_vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      pw_sp_q[j]  <= sp_d;
      pw_ctx_q[j] <= pw_ctx_q[j-1];
    end
  end

  // ---------------- basis polynomials
  ptsmp_pkg::h_t   h_all [3][5][3];
  ptsmp_pkg::h_t   h_q   [5][3];
  ptsmp_pkg::h_t   h_d   [5][3];
  logic            h_vld_q;
  ptsmp_pkg::ctx_t h_ctx_q;

  for (genvar o = 0; o < 3; o++) begin : g_ord
    for (genvar g = 0; g < 5; g++) begin : g_grp
      for (genvar k = 0; k < 3; k++) begin : g_der
        always_comb begin
          ptsmp_pkg::h_t acc;
          acc = '0;
          for (int i = 0; i < 6; i++) begin
            acc = acc + ptsmp_pkg::h_t'(ptsmp_pkg::BASIS[o][g][k][i])
                      * ptsmp_pkg::h_t'($signed({1'b0, pw_sp_q[4][i]}));
          end
          h_all[o][g][k] = acc;
        end
      end
    end
  end

  always_comb begin
    for (int g = 0; g < 5; g++) begin
      for (int k = 0; k < 3; k++) begin
        case (pw_ctx_q[4].ord)
          ptsmp_pkg::ORD_LIN: h_d[g][k] = h_all[0][g][k];
          ptsmp_pkg::ORD_CUB: h_d[g][k] = h_all[1][g][k];
          default:            h_d[g][k] = h_all[2][g][k];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= pw_vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    h_ctx_q <= pw_ctx_q[4];
  end

  // ---------------- value times basis
  logic signed [32:0] val_w [5];
  ptsmp_pkg::val_t    tm_y   [5][3];
  logic               tm_vld [5][3];
  ptsmp_pkg::ctx_t    tm_ctx [5][3];

  always_comb begin
    val_w[0] = h_ctx_q.dx;
    val_w[1] = 33'(h_ctx_q.v0);
    val_w[2] = 33'(h_ctx_q.vf);
    val_w[3] = 33'(h_ctx_q.a0);
    val_w[4] = 33'(h_ctx_q.af);
  end

  for (genvar g = 0; g < 5; g++) begin : g_tg
    for (genvar k = 0; k < 3; k++) begin : g_tk
      ptsmp_mulsh #(
        .AW     (33),
        .BW     (ptsmp_pkg::H_W),
        .SH     (31),
        .side_t (ptsmp_pkg::ctx_t)
      ) u_term (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .vld_i  (h_vld_q),
        .side_i (h_ctx_q),
        .a_i    (val_w[g]),
        .b_i    (h_q[g][k]),
        .vld_o  (tm_vld[g][k]),
        .side_o (tm_ctx[g][k]),
        .y_o    (tm_y[g][k])
      );
    end
  end

  // ---------------- group sums
  logic            g_vld_q;
  ptsmp_pkg::ctx_t g_ctx_q, g_ctx_d;

  always_comb begin
    g_ctx_d = tm_ctx[0][0];
    for (int k = 0; k < 3; k++) begin
      g_ctx_d.gd[k] = tm_y[0][k];
      g_ctx_d.gv[k] = ptsmp_pkg::sat_add(tm_y[1][k], tm_y[2][k]);
      g_ctx_d.ga[k] = ptsmp_pkg::sat_add(tm_y[3][k], tm_y[4][k]);
    end
    g_ctx_d.pacc = ptsmp_pkg::sat_add(ptsmp_pkg::val_t'(tm_ctx[0][0].x0), tm_y[0][0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= tm_vld[0][0];
    end
  end

  always_ff @(posedge clk_i) begin
    g_ctx_q <= g_ctx_d;
  end

  // ---------------- products with T
  logic signed [32:0] g_tdur;
  ptsmp_pkg::val_t    m1_a [3];
  ptsmp_pkg::val_t    m1_y [3];
  logic               m1_vld [3];
  ptsmp_pkg::ctx_t    m1_ctx [3];

  always_comb begin
    g_tdur  = $signed({1'b0, g_ctx_q.tdur});
    m1_a[0] = g_ctx_q.gv[0];
    m1_a[1] = g_ctx_q.ga[0];
    m1_a[2] = g_ctx_q.ga[1];
  end

  for (genvar m = 0; m < 3; m++) begin : g_m1
    ptsmp_mulsh #(
      .AW     (ptsmp_pkg::VAL_W),
      .BW     (33),
      .SH     (ptsmp_pkg::DIV_FRAC),
      .side_t (ptsmp_pkg::ctx_t)
    ) u_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (g_vld_q),
      .side_i (g_ctx_q),
      .a_i    (m1_a[m]),
      .b_i    (g_tdur),
      .vld_o  (m1_vld[m]),
      .side_o (m1_ctx[m]),
      .y_o    (m1_y[m])
    );
  end

  logic            c1_vld_q;
  ptsmp_pkg::ctx_t c1_ctx_q, c1_ctx_d;

  always_comb begin
    c1_ctx_d      = m1_ctx[0];
    c1_ctx_d.pacc = ptsmp_pkg::sat_add(m1_ctx[0].pacc, m1_y[0]);
    c1_ctx_d.a_t  = m1_y[1];
    c1_ctx_d.v_t  = m1_y[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
    end else begin
      c1_vld_q <= m1_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    c1_ctx_q <= c1_ctx_d;
  end

  logic signed [32:0] c1_tdur;
  logic               m2_vld;
  ptsmp_pkg::ctx_t    m2_ctx;
  ptsmp_pkg::val_t    m2_y;

  assign c1_tdur = $signed({1'b0, c1_ctx_q.tdur});

  ptsmp_mulsh #(
    .AW     (ptsmp_pkg::VAL_W),
    .BW     (33),
    .SH     (ptsmp_pkg::DIV_FRAC),
    .side_t (ptsmp_pkg::ctx_t)
  ) u_mul_tt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c1_vld_q),
    .side_i (c1_ctx_q),
    .a_i    (c1_ctx_q.a_t),
    .b_i    (c1_tdur),
    .vld_o  (m2_vld),
    .side_o (m2_ctx),
    .y_o    (m2_y)
  );

  logic            c2_vld_q;
  ptsmp_pkg::ctx_t c2_ctx_q, c2_ctx_d;

  always_comb begin
    c2_ctx_d      = m2_ctx;
    c2_ctx_d.pacc = ptsmp_pkg::sat_add(m2_ctx.pacc, m2_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_vld_q <= 1'b0;
    end else begin
      c2_vld_q <= m2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c2_ctx_q <= c2_ctx_d;
  end

  // ---------------- divisions by T
  ptsmp_pkg::val_t d1_a   [3];
  ptsmp_pkg::val_t d1_y   [3];
  logic            d1_vld [3];
  ptsmp_pkg::ctx_t d1_ctx [3];

  always_comb begin
    d1_a[0] = c2_ctx_q.gd[1];
    d1_a[1] = c2_ctx_q.gd[2];
    d1_a[2] = c2_ctx_q.gv[2];
  end

  for (genvar m = 0; m < 3; m++) begin : g_d1
    ptsmp_divt #(.side_t(ptsmp_pkg::ctx_t)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c2_vld_q),
      .side_i (c2_ctx_q),
      .a_i    (d1_a[m]),
      .d_i    (c2_ctx_q.tdur),
      .vld_o  (d1_vld[m]),
      .side_o (d1_ctx[m]),
      .y_o    (d1_y[m])
    );
  end

  logic            c3_vld_q;
  ptsmp_pkg::ctx_t c3_ctx_q, c3_ctx_d;

  always_comb begin
    c3_ctx_d      = d1_ctx[0];
    c3_ctx_d.vacc = ptsmp_pkg::sat_add(
                      ptsmp_pkg::sat_add(d1_y[0], d1_ctx[0].gv[1]), d1_ctx[0].v_t);
    c3_ctx_d.dd   = d1_y[1];
    c3_ctx_d.dgv  = d1_y[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_vld_q <= 1'b0;
    end else begin
      c3_vld_q <= d1_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    c3_ctx_q <= c3_ctx_d;
  end

  logic            d2_vld;
  ptsmp_pkg::ctx_t d2_ctx;
  ptsmp_pkg::val_t d2_y;

  ptsmp_divt #(.side_t(ptsmp_pkg::ctx_t)) u_div_dd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c3_vld_q),
    .side_i (c3_ctx_q),
    .a_i    (c3_ctx_q.dd),
    .d_i    (c3_ctx_q.tdur),
    .vld_o  (d2_vld),
    .side_o (d2_ctx),
    .y_o    (d2_y)
  );

  // ---------------- output register
  logic            valid_q;
  ptsmp_pkg::out_t result_q, result_d;
  ptsmp_pkg::val_t aacc;

  always_comb begin
    aacc = ptsmp_pkg::sat_add(ptsmp_pkg::sat_add(d2_y, d2_ctx.dgv), d2_ctx.ga[2]);
    if (d2_ctx.spec) begin
      result_d.next_pos = d2_ctx.sp_pos;
      result_d.next_vel = d2_ctx.sp_vel;
      result_d.next_acc = d2_ctx.sp_acc;
    end else begin
      result_d.next_pos = ptsmp_pkg::to_q16(d2_ctx.pacc);
      result_d.next_vel = ptsmp_pkg::to_q16(d2_ctx.vacc);
      result_d.next_acc = ptsmp_pkg::to_q16(aacc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
